// ===== hdl/aorq_pkg.sv =====
// shared types and constants for the aging overwrite ring queue
`timescale 1ns / 1ps

package aorq_pkg;

  localparam int TIME_BITS = 64;
  localparam int FIELD_BITS = 64;
  localparam int WINDOW_BITS = 32;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 32'd500;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_GET_FRONT = 2'd1;
  localparam logic [1:0] OP_POP = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic shift;   // take the upstream neighbor's entry
    logic append;  // first free cell loads the new entry
    logic clear;   // drop every entry
  } ctl_t;

endpackage

// ===== hdl/aorq_cell.sv =====
// one slot of the queue chain: occupancy flag, timestamp and payload
`timescale 1ns / 1ps

module aorq_cell #(
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  aorq_pkg::ctl_t                 ctl,
  input  logic                           prev_occ,
  input  logic                           nbr_occ,
  input  logic [aorq_pkg::TIME_BITS-1:0] nbr_time,
  input  logic [PAYLOAD_BITS-1:0]        nbr_payload,
  input  logic [aorq_pkg::TIME_BITS-1:0] new_time,
  input  logic [PAYLOAD_BITS-1:0]        new_payload,
  output logic                           occ,
  output logic [aorq_pkg::TIME_BITS-1:0] entry_time,
  output logic [PAYLOAD_BITS-1:0]        entry_payload
);

  logic take_new;

  // the lowest free cell sits right above the last occupied one
  assign take_new = ctl.append && !occ && prev_occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.clear) begin
      occ <= 1'b0;
    end else if (ctl.shift) begin
      occ <= nbr_occ;
    end else if (take_new) begin
      occ <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry_time    <= nbr_time;
      entry_payload <= nbr_payload;
    end else if (take_new) begin
      entry_time    <= new_time;
      entry_payload <= new_payload;
    end
  end

endmodule

// ===== hdl/aging_overwrite_ring_queue_unit.sv =====
// top level of the aging overwrite ring queue: control, cell chain and result buffer
`timescale 1ns / 1ps

// Queue of up to QUEUE_SLOTS-1 timestamped entries, built as a chain of cells with the
// oldest entry always in cell 0. Each item carries an operation: push appends an entry
// (dropping the oldest when full), pop drops the front entry, clear empties the queue, and
// get front first discards every front entry whose time is below now_time minus
// discard_window_ms (64-bit wrapping) and then reports the front entry, or front_valid low
// when empty. Push, pop and clear return an all-zero result. During get front the chain
// shifts one expired entry out per cycle while the front cell's timestamp is compared
// against the threshold. A two-entry result buffer lets a new item in while an earlier
// result waits on m_tready. The window register is written through cfg_wen / cfg_wdata;
// the user must write it only while the block is idle, which the block itself does not
// enforce. It resets to 500.

module aging_overwrite_ring_queue_unit #(
  parameter int QUEUE_SLOTS  = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  // operation [1:0], now_time [65:2], entry_time [129:66], entry_payload [193:130]
  input  logic [199:0] s_tdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // front_time [63:0], front_payload [127:64]
  output logic [127:0] m_tdata,
  // front_valid [0]
  output logic [0:0]   m_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_wen,
  input  logic [31:0]  cfg_wdata
);

  localparam int CAP = QUEUE_SLOTS - 1;
  localparam int TB  = aorq_pkg::TIME_BITS;
  localparam int FB  = aorq_pkg::FIELD_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_AGE  = 1'b1;

  typedef struct packed {
    logic          front_valid;
    logic [TB-1:0] front_time;
    logic [FB-1:0] front_payload;
  } res_t;

  // input fields
  logic [1:0]              in_op;
  logic [TB-1:0]           in_now;
  logic [TB-1:0]           in_time;
  logic [PAYLOAD_BITS-1:0] in_payload;

  assign in_op      = s_tdata[1:0];
  assign in_now     = s_tdata[65:2];
  assign in_time    = s_tdata[129:66];
  assign in_payload = s_tdata[130 +: PAYLOAD_BITS];

  // window register
  logic [aorq_pkg::WINDOW_BITS-1:0] window;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= aorq_pkg::WINDOW_RESET;
    end else if (cfg_wen) begin
      window <= cfg_wdata;
    end
  end

  // control
  logic          state;
  logic [TB-1:0] thr;
  logic          accept;
  logic          pop_out;
  logic          room;
  logic          front_old;
  logic          res_push;
  res_t          res;
  logic          hold_valid;
  aorq_pkg::ctl_t ctl;

  // chain wiring: index CAP is the feed into the tail cell
  logic                    occ_chain [0:CAP];
  logic [TB-1:0]           time_chain [0:CAP];
  logic [PAYLOAD_BITS-1:0] pay_chain [0:CAP];

  assign accept  = s_tvalid && s_tready;
  assign pop_out = m_tvalid && m_tready;
  assign room    = !hold_valid || pop_out;
  assign s_tready = (state == ST_IDLE) && !hold_valid;

  // expired front entry while aging
  assign front_old = occ_chain[0] && (time_chain[0] < thr);

  always_comb begin
    ctl = '0;
    if (accept) begin
      unique case (in_op)
        aorq_pkg::OP_PUSH: begin
          // a full queue shifts the oldest out and the tail cell takes the new entry
          ctl.shift  = occ_chain[CAP-1];
          ctl.append = !occ_chain[CAP-1];
        end
        aorq_pkg::OP_POP:       ctl.shift = 1'b1;
        aorq_pkg::OP_CLEAR:     ctl.clear = 1'b1;
        aorq_pkg::OP_GET_FRONT: ctl = '0;
        default:                ctl = '0;
      endcase
    end else if (state == ST_AGE) begin
      ctl.shift = front_old;
    end
  end

  // tail feed is marked occupied for every accepted push; only a push into a full queue shifts it in
  assign occ_chain[CAP]  = accept && (in_op == aorq_pkg::OP_PUSH);
  assign time_chain[CAP] = in_time;
  assign pay_chain[CAP]  = in_payload;

  genvar gi;
  generate
    for (gi = 0; gi < CAP; gi++) begin : g_cell
      logic prev_occ;
      if (gi == 0) begin : g_head
        assign prev_occ = 1'b1;
      end else begin : g_body
        assign prev_occ = occ_chain[gi-1];
      end
      aorq_cell #(
        .PAYLOAD_BITS(PAYLOAD_BITS)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .ctl          (ctl),
        .prev_occ     (prev_occ),
        .nbr_occ      (occ_chain[gi+1]),
        .nbr_time     (time_chain[gi+1]),
        .nbr_payload  (pay_chain[gi+1]),
        .new_time     (in_time),
        .new_payload  (in_payload),
        .occ          (occ_chain[gi]),
        .entry_time   (time_chain[gi]),
        .entry_payload(pay_chain[gi])
      );
    end
  endgenerate

  // state and aging threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (accept && in_op == aorq_pkg::OP_GET_FRONT) begin
          state <= ST_AGE;
        end
        ST_AGE: if (!front_old && room) begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // threshold wraps modulo 2^64
  always_ff @(posedge clk) begin
    if (accept) begin
      thr <= in_now - TB'(window);
    end
  end

  // result of the current step
  always_comb begin
    res = '0;
    if (state == ST_AGE && occ_chain[0]) begin
      res.front_valid   = 1'b1;
      res.front_time    = time_chain[0];
      res.front_payload = FB'(pay_chain[0]);
    end
  end

  assign res_push = (accept && in_op != aorq_pkg::OP_GET_FRONT)
                 || (state == ST_AGE && !front_old && room);

  // two-entry result buffer: out drives the port, hold catches a result while out stalls
  logic out_valid;
  res_t out_res;
  res_t hold_res;
  logic out_valid_next;
  logic hold_valid_next;
  res_t out_res_next;
  res_t hold_res_next;

  always_comb begin
    out_valid_next  = out_valid;
    hold_valid_next = hold_valid;
    out_res_next    = out_res;
    hold_res_next   = hold_res;
    if (pop_out) begin
      if (hold_valid) begin
        out_res_next    = hold_res;
        hold_valid_next = 1'b0;
      end else begin
        out_valid_next = 1'b0;
      end
    end
    if (res_push) begin
      if (!out_valid_next) begin
        out_res_next   = res;
        out_valid_next = 1'b1;
      end else begin
        hold_res_next   = res;
        hold_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_res  <= out_res_next;
    hold_res <= hold_res_next;
  end

  assign m_tvalid      = out_valid;
  assign m_tdata       = {out_res.front_payload, out_res.front_time};
  assign m_tuser[0]    = out_res.front_valid;

endmodule

// ===== bench/aging_overwrite_ring_queue_unit_tb.sv =====
// self-checking bench for the aging overwrite ring queue: directed and random operations
`timescale 1ns / 1ps

module aging_overwrite_ring_queue_unit_tb;

  localparam int QUEUE_SLOTS = 16;
  localparam int PHASE_ITEMS = 75;   // six random phases, about 450 items in all
  localparam int HOLD_CYCLES = 300;  // long output stall, fills the result buffer

  logic         clk = 1'b0;
  logic         rst;
  logic [199:0] s_tdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic         cfg_wen;
  logic [31:0]  cfg_wdata;

  // pacing knobs shared by the sender and the receiver
  bit steady = 1'b0;       // no random idle cycles on either side while set
  bit hold_output = 1'b0;  // receiver starts one long stall when set

  always #6 clk = ~clk;

  aging_overwrite_ring_queue_unit #(
    .QUEUE_SLOTS(QUEUE_SLOTS),
    .PAYLOAD_BITS(64)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  // shadow of the queue: predicts the front report for every accepted item
  class ring_front_checker;
    typedef struct packed {
      logic        valid;
      logic [63:0] stamp;
      logic [63:0] data;
    } front_t;

    logic [63:0] slot_time [QUEUE_SLOTS];
    logic [63:0] slot_payload [QUEUE_SLOTS];
    int          head;
    int          tail;
    logic [31:0] window;
    front_t      pending_fronts [$];
    int          mismatches;

    function new();
      head = 0;
      tail = 0;
      window = aorq_pkg::WINDOW_RESET;
      mismatches = 0;
    endfunction

    function int step(int slot);
      return (slot + 1 == QUEUE_SLOTS) ? 0 : slot + 1;
    endfunction

    function void set_window(logic [31:0] value);
      window = value;
    endfunction

    function int pending();
      return pending_fronts.size();
    endfunction

    // apply one accepted operation and queue the report it must produce
    function void note_item(logic [199:0] word);
      logic [1:0]  op;
      logic [63:0] now;
      logic [63:0] stamp;
      logic [63:0] data;
      logic [63:0] limit;
      front_t      res;
      op = word[1:0];
      now = word[65:2];
      stamp = word[129:66];
      data = word[193:130];
      res = '{1'b0, 64'd0, 64'd0};
      case (op)
        aorq_pkg::OP_PUSH: begin
          // full queue: oldest entry goes first
          if (step(tail) == head) head = step(head);
          slot_time[tail] = stamp;
          slot_payload[tail] = data;
          tail = step(tail);
        end
        aorq_pkg::OP_GET_FRONT: begin
          // threshold wraps modulo 2^64 when the window exceeds now
          limit = now - {32'd0, window};
          for (int n = 0; n < QUEUE_SLOTS && head != tail; n++) begin
            if (slot_time[head] >= limit) break;
            head = step(head);
          end
          if (head != tail) res = '{1'b1, slot_time[head], slot_payload[head]};
        end
        aorq_pkg::OP_POP: begin
          if (head != tail) head = step(head);
        end
        aorq_pkg::OP_CLEAR: begin
          head = 0;
          tail = 0;
        end
      endcase
      pending_fronts.push_back(res);
    endfunction

    function void check_front(logic valid, logic [63:0] stamp, logic [63:0] data);
      front_t want;
      if (pending_fronts.size() == 0) begin
        $display("%0t: result with no item waiting, expected none, actual %b %h %h",
                 $time, valid, stamp, data);
        mismatches++;
        return;
      end
      want = pending_fronts.pop_front();
      if (want.valid !== valid) begin
        $display("%0t: front_valid mismatch, expected %b, actual %b", $time, want.valid, valid);
        mismatches++;
      end
      if (want.stamp !== stamp) begin
        $display("%0t: front_time mismatch, expected %h, actual %h", $time, want.stamp, stamp);
        mismatches++;
      end
      if (want.data !== data) begin
        $display("%0t: front_payload mismatch, expected %h, actual %h", $time, want.data, data);
        mismatches++;
      end
    endfunction
  endclass

  ring_front_checker board;

  // handshakes are sampled on the pre-edge values; results first, so a result
  // never meets the expectation of the item accepted on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_front(m_tuser[0], m_tdata[63:0], m_tdata[127:64]);
      if (s_tvalid && s_tready) board.note_item(s_tdata);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_below(logic [63:0] bound);
    return rand64() % bound;
  endfunction

  // receiver: random back-pressure, plus one long stall on request
  initial begin
    forever begin
      if (hold_output) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else if (!steady && $urandom_range(0, 9) < 3) begin
        m_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one item and wait until the block takes it; valid stays high afterwards
  task automatic send_item(logic [1:0] op, logic [63:0] now, logic [63:0] stamp,
                           logic [63:0] data);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // operation, now_time, entry_time, entry_payload from bit 0 up, zero pad on top
    s_tdata <= {6'd0, data, stamp, now, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  // stop offering and let every expected report come back
  task automatic drain();
    s_tvalid <= 1'b0;
    // let the monitor note the last accepted item before counting pending reports
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    // a get front may still be walking the chain
    repeat (QUEUE_SLOTS + 4) @(posedge clk);
  endtask

  task automatic write_window(logic [31:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    board.set_window(value);
  endtask

  // mostly coherent traffic around a running clock, the rest pure noise
  task automatic random_item(inout logic [63:0] clock_ms, input logic [63:0] win);
    logic [1:0]  op;
    logic [63:0] now;
    logic [63:0] stamp;
    int          roll;
    roll = $urandom_range(0, 99);
    now = rand64();
    stamp = rand64();
    op = 2'($urandom_range(0, 3));
    if (roll >= 12) begin
      if (roll < 58) begin
        op = aorq_pkg::OP_PUSH;
        clock_ms += rand_below(win / 64'd4 + 64'd4);
        stamp = clock_ms - rand_below(64'd16);
      end else if (roll < 88) begin
        // lands on both sides of the expiry threshold
        op = aorq_pkg::OP_GET_FRONT;
        now = clock_ms + rand_below(win + win / 64'd2 + 64'd16);
      end else if (roll < 98) begin
        op = aorq_pkg::OP_POP;
      end else begin
        op = aorq_pkg::OP_CLEAR;
      end
    end
    send_item(op, now, stamp, rand64());
  endtask

  // run limit, far above the slowest legal run
  initial begin
    #4ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [31:0] windows [6];
    logic [63:0] clock_ms;
    board = new();
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_wen <= 1'b0;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part, window at its reset value
    send_item(aorq_pkg::OP_GET_FRONT, 64'd0, rand64(), rand64());   // empty get front
    send_item(aorq_pkg::OP_POP, rand64(), rand64(), rand64());       // pop on empty
    send_item(aorq_pkg::OP_PUSH, rand64(), 64'd100, 64'd0);
    send_item(aorq_pkg::OP_PUSH, rand64(), 64'd1000, '1);
    send_item(aorq_pkg::OP_GET_FRONT, 64'd1000, '0, '0);              // old entry expires
    send_item(aorq_pkg::OP_POP, '1, '1, '1);
    // overfill: the sixteenth push overwrites the oldest entry
    for (int i = 0; i < QUEUE_SLOTS; i++) begin
      send_item(aorq_pkg::OP_PUSH, '0, 64'd2000 + i, 64'hA5A5_0000_0000_0000 + i);
    end
    send_item(aorq_pkg::OP_GET_FRONT, 64'd2000, '0, '0);
    send_item(aorq_pkg::OP_PUSH, '0, '1, 64'h5555_5555_5555_5555);
    // now below the window: threshold wraps and expires all but the newest
    send_item(aorq_pkg::OP_GET_FRONT, 64'd10, '0, '0);
    send_item(aorq_pkg::OP_CLEAR, '1, '1, '1);
    send_item(aorq_pkg::OP_GET_FRONT, '1, '0, '0);
    send_item(aorq_pkg::OP_PUSH, '1, '0, '0);
    send_item(aorq_pkg::OP_GET_FRONT, '1, '1, '1);                    // entry expires
    drain();

    windows[0] = 32'd0;
    windows[1] = $urandom_range(1, 8);
    windows[2] = 32'hFFFF_FFFF;
    windows[3] = $urandom_range(100, 3000);
    windows[4] = $urandom;
    windows[5] = aorq_pkg::WINDOW_RESET;

    for (int p = 0; p < 6; p++) begin
      write_window(windows[p]);
      case (p % 3)
        0: clock_ms = rand_below(64'd2000);
        1: clock_ms = rand64();
        default: clock_ms = 64'hFFFF_FFFF_FFFF_FFFF - rand_below(64'h4_0000_0000);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 25 == 0) steady = ($urandom_range(0, 3) == 0);
        // output held off while the sender keeps offering
        if (p == 1 && i == 10) hold_output = 1'b1;
        random_item(clock_ms, {32'd0, windows[p]});
      end
      steady = 1'b0;
      drain();
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== aging_overwrite_ring_queue_unit.f =====
hdl/aorq_pkg.sv
hdl/aorq_cell.sv
hdl/aging_overwrite_ring_queue_unit.sv
bench/aging_overwrite_ring_queue_unit_tb.sv
